// ===== rtl/skvt_pkg.sv =====
// Shared types for the sorted key/value table.
// Holds the request status codes, the sequencer state type and the result record.
// No dependencies.
package skvt_pkg;

    typedef enum logic [1:0] {
        STATUS_HIT   = 2'd0,
        STATUS_MISS  = 2'd1,
        STATUS_WRITE = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_VALUE_RD,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] found_value;
        logic [6:0]  entry_count;
    } result_t;

endpackage

// ===== rtl/sorted_key_value_table_unit.sv =====
// Top level of the sorted key/value table: sequencer, key and value RAMs, result register.
// Depends on skvt_pkg, skvt_ram and skvt_seq.
//
//   channel  direction  ports                                           transfer when
//   s_       in         s_req_type, s_lookup_key, s_entry_value         s_valid && s_ready
//   m_       out        m_status, m_found_value, m_entry_count          m_valid && m_ready
//
// Binary search makes each probe as a RAM read (S_SEARCH), then a compare (S_COMPARE).
// A lookup hit adds a value read (S_VALUE_RD); insert of a new key moves each entry above
// the insertion point up by one, with a read (S_SHIFT_RD) and a write (S_SHIFT_WR) per entry.
// aresetn clears the sequencer and the fill count; RAM contents stay undefined.
// A new request is taken while the previous result waits in the output register.
module sorted_key_value_table_unit
    import skvt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [15:0] s_lookup_key,
    input  logic [31:0] s_entry_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_found_value,
    output logic [6:0]  m_entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic          res_valid;
    logic          res_ready;
    result_t       res;
    logic [AW-1:0] ram_raddr;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   key_rdata;
    logic [31:0]   val_rdata;
    logic          key_we;
    logic          val_we;
    logic [15:0]   key_wdata;
    logic [31:0]   val_wdata;

    logic          m_valid_reg;
    result_t       m_res_reg;

    skvt_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_req_type (s_req_type),
        .in_key      (s_lookup_key),
        .in_value    (s_entry_value),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_raddr   (ram_raddr),
        .key_rdata   (key_rdata),
        .val_rdata   (val_rdata),
        .key_we      (key_we),
        .val_we      (val_we),
        .ram_waddr   (ram_waddr),
        .key_wdata   (key_wdata),
        .val_wdata   (val_wdata)
    );

    skvt_ram #(
        .WIDTH (16),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (ram_waddr),
        .wdata (key_wdata),
        .raddr (ram_raddr),
        .rdata (key_rdata)
    );

    skvt_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (ram_waddr),
        .wdata (val_wdata),
        .raddr (ram_raddr),
        .rdata (val_rdata)
    );

    // output register frees the sequencer as soon as the slot is empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_res_reg.status;
    assign m_found_value = m_res_reg.found_value;
    assign m_entry_count = m_res_reg.entry_count;

endmodule

// ===== rtl/skvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skvt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/skvt_seq.sv =====
// Search and shift sequencer for the sorted key/value table.
// Drives the key and value RAMs through one read and one write port each.
// Depends on skvt_pkg.
module skvt_seq
    import skvt_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    // request
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          in_req_type,
    input  logic [15:0]   in_key,
    input  logic [31:0]   in_value,
    // result
    output logic          res_valid,
    input  logic          res_ready,
    output result_t       res,
    // RAM ports
    output logic [AW-1:0] ram_raddr,
    input  logic [15:0]   key_rdata,
    input  logic [31:0]   val_rdata,
    output logic          key_we,
    output logic          val_we,
    output logic [AW-1:0] ram_waddr,
    output logic [15:0]   key_wdata,
    output logic [31:0]   val_wdata
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    seq_state_t     state_reg, state_next;
    logic           insert_reg, insert_next;
    logic [15:0]    key_reg, key_next;
    logic [31:0]    value_reg, value_next;
    logic [CW-1:0]  lo_reg, lo_next;
    logic [CW-1:0]  hi_reg, hi_next;
    logic [CW-1:0]  mid_reg, mid_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  fill_reg, fill_next;
    result_t        res_reg, res_next;

    logic [CW:0]    mid_sum;
    logic [CW-1:0]  mid_w;
    logic [CW-1:0]  idx_dec;
    logic [CW-1:0]  fill_inc;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_w    = mid_sum[CW:1];
    assign idx_dec  = idx_reg - ONE_C;
    assign fill_inc = fill_reg + ONE_C;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        insert_reg <= insert_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
    end

    always_comb begin
        state_next  = state_reg;
        insert_next = insert_reg;
        key_next    = key_reg;
        value_next  = value_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        fill_next   = fill_reg;
        res_next    = res_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        ram_raddr = mid_reg[AW-1:0];
        key_we    = 1'b0;
        val_we    = 1'b0;
        ram_waddr = pos_reg[AW-1:0];
        key_wdata = key_reg;
        val_wdata = value_reg;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    insert_next = in_req_type;
                    key_next    = in_key;
                    value_next  = in_value;
                    lo_next     = '0;
                    hi_next     = fill_reg;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH: begin
                ram_raddr = mid_w[AW-1:0];
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_w;
                    state_next = S_COMPARE;
                end else begin
                    // key absent; lo is the insertion point
                    pos_next = lo_reg;
                    if (!insert_reg) begin
                        res_next   = '{STATUS_MISS, 32'd0, 7'(fill_reg)};
                        state_next = S_DONE;
                    end else if (fill_reg >= CAP_C) begin
                        res_next   = '{STATUS_FULL, 32'd0, 7'(fill_reg)};
                        state_next = S_DONE;
                    end else begin
                        idx_next   = fill_reg;
                        state_next = S_SHIFT_RD;
                    end
                end
            end
            S_COMPARE: begin
                if (key_rdata < key_reg) begin
                    lo_next    = mid_reg + ONE_C;
                    state_next = S_SEARCH;
                end else if (key_rdata > key_reg) begin
                    hi_next    = mid_reg;
                    state_next = S_SEARCH;
                end else if (insert_reg) begin
                    // existing key: overwrite value in place
                    val_we     = 1'b1;
                    ram_waddr  = mid_reg[AW-1:0];
                    res_next   = '{STATUS_WRITE, 32'd0, 7'(fill_reg)};
                    state_next = S_DONE;
                end else begin
                    state_next = S_VALUE_RD;
                end
            end
            S_VALUE_RD: begin
                res_next   = '{STATUS_HIT, val_rdata, 7'(fill_reg)};
                state_next = S_DONE;
            end
            S_SHIFT_RD: begin
                if (idx_reg > pos_reg) begin
                    ram_raddr  = idx_dec[AW-1:0];
                    state_next = S_SHIFT_WR;
                end else begin
                    key_we     = 1'b1;
                    val_we     = 1'b1;
                    fill_next  = fill_inc;
                    res_next   = '{STATUS_WRITE, 32'd0, 7'(fill_inc)};
                    state_next = S_DONE;
                end
            end
            S_SHIFT_WR: begin
                // move entry idx-1 up to idx
                key_we     = 1'b1;
                val_we     = 1'b1;
                ram_waddr  = idx_reg[AW-1:0];
                key_wdata  = key_rdata;
                val_wdata  = val_rdata;
                idx_next   = idx_dec;
                state_next = S_SHIFT_RD;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CAP_C)
        else $error("fill count above capacity");

    a_search_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH) |-> (lo_reg <= hi_reg && hi_reg <= fill_reg))
        else $error("search bounds out of order");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && $past(aresetn)) |->
            (fill_reg == $past(fill_reg) || fill_reg == $past(fill_reg) + ONE_C))
        else $error("fill count moved by more than one");

    a_shift_above_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT_WR) |-> (idx_reg > pos_reg && idx_reg < CAP_C))
        else $error("shift write outside the moved range");

    a_done_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_ready) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after result transfer");

endmodule

// ===== bench/sorted_key_value_table_unit_tb.sv =====
// Self-checking bench for sorted_key_value_table_unit: lookups, inserts, updates, full refusals.
// Keeps its own sorted table to predict every result; depends on skvt_pkg and the RTL top.
module sorted_key_value_table_unit_tb
    import skvt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 700;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 300;

    localparam bit REQ_LOOKUP = 1'b0;
    localparam bit REQ_INSERT = 1'b1;

    localparam int PH_FREE     = 0;
    localparam int PH_SRC_IDLE = 1;
    localparam int PH_SNK_IDLE = 2;
    localparam int PH_BOTH     = 3;

    typedef struct {
        bit          req;
        logic [15:0] key;
        logic [31:0] value;
        int          phase;
        bit          drain;
    } table_request_t;

    typedef struct {
        status_t     status;
        logic [31:0] found_value;
        logic [6:0]  entry_count;
    } table_reply_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_req_type    = 1'b0;
    logic [15:0] s_lookup_key  = '0;
    logic [31:0] s_entry_value = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_found_value;
    logic [6:0]  m_entry_count;

    table_request_t pending_reqs[$];
    table_reply_t   expected_replies[$];
    table_reply_t   oldest_reply;

    // predicted table contents
    logic [15:0] tbl_key [CAPACITY];
    logic [31:0] tbl_val [CAPACITY];
    int          tbl_count = 0;

    // stimulus-time shadow of which keys will be present
    bit          gen_known [65536];
    logic [15:0] gen_keys[$];

    int phase      = PH_FREE;
    int fail_count = 0;
    int idle_count = 0;

    sorted_key_value_table_unit #(.CAPACITY(CAPACITY)) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_lookup_key  (s_lookup_key),
        .s_entry_value (s_entry_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_value (m_found_value),
        .m_entry_count (m_entry_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int src_idle_pct(int ph);
        if (ph == PH_SRC_IDLE) return 88;
        if (ph == PH_BOTH) return 34;
        return 0;
    endfunction

    function automatic int snk_stall_pct(int ph);
        if (ph == PH_SNK_IDLE) return 88;
        if (ph == PH_BOTH) return 34;
        return 0;
    endfunction

    // Updates the predicted table and returns the reply for one request.
    function automatic table_reply_t apply_request(bit req, logic [15:0] key, logic [31:0] value);
        table_reply_t r;
        int pos;
        int i;
        bit hit;
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] < key) pos++;
        hit = (pos < tbl_count) && (tbl_key[pos] == key);
        r.found_value = '0;
        if (req == REQ_LOOKUP) begin
            if (hit) begin
                r.status = STATUS_HIT;
                r.found_value = tbl_val[pos];
            end else begin
                r.status = STATUS_MISS;
            end
        end else if (hit) begin
            tbl_val[pos] = value;
            r.status = STATUS_WRITE;
        end else if (tbl_count >= CAPACITY) begin
            r.status = STATUS_FULL;
        end else begin
            for (i = tbl_count; i > pos; i--) begin
                tbl_key[i] = tbl_key[i-1];
                tbl_val[i] = tbl_val[i-1];
            end
            tbl_key[pos] = key;
            tbl_val[pos] = value;
            tbl_count++;
            r.status = STATUS_WRITE;
        end
        r.entry_count = 7'(tbl_count);
        return r;
    endfunction

    task automatic add_request(bit req, logic [15:0] key, logic [31:0] value, int ph, bit drain);
        table_request_t t;
        t.req = req;
        t.key = key;
        t.value = value;
        t.phase = ph;
        t.drain = drain;
        pending_reqs.push_back(t);
        if (req == REQ_INSERT && !gen_known[key] && gen_keys.size() < CAPACITY) begin
            gen_known[key] = 1'b1;
            gen_keys.push_back(key);
        end
    endtask

    function automatic logic [15:0] pick_key(int known_pct);
        if (gen_keys.size() != 0 && $urandom_range(99) < known_pct)
            return gen_keys[$urandom_range(gen_keys.size() - 1)];
        return 16'($urandom);
    endfunction

    // Driver: presents queued requests, records the prediction on each transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_replies.push_back(apply_request(s_req_type, s_lookup_key, s_entry_value));
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending_reqs[0].drain && expected_replies.size() != 0) begin
                    s_valid <= 1'b0;
                end else if ($urandom_range(99) < src_idle_pct(phase)) begin
                    s_valid <= 1'b0;
                end else begin
                    s_valid       <= 1'b1;
                    s_req_type    <= pending_reqs[0].req;
                    s_lookup_key  <= pending_reqs[0].key;
                    s_entry_value <= pending_reqs[0].value;
                    phase         <= pending_reqs[0].phase;
                    void'(pending_reqs.pop_front());
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    $error("result with nothing expected: status %0d value %h count %0d",
                           m_status, m_found_value, m_entry_count);
                    fail_count++;
                end else begin
                    oldest_reply = expected_replies.pop_front();
                    if (m_status !== oldest_reply.status) begin
                        $error("status: expected %0d, got %0d", oldest_reply.status, m_status);
                        fail_count++;
                    end
                    if (m_found_value !== oldest_reply.found_value) begin
                        $error("found_value: expected %h, got %h",
                               oldest_reply.found_value, m_found_value);
                        fail_count++;
                    end
                    if (m_entry_count !== oldest_reply.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               oldest_reply.entry_count, m_entry_count);
                        fail_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= snk_stall_pct(phase));
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int n;
        int ph;
        bit req;
        logic [15:0] key;

        // directed: empty table, key extremes, middle insert, updates, front shift
        add_request(REQ_LOOKUP, 16'h0000, 32'h0000_0000, PH_FREE, 1'b0);
        add_request(REQ_LOOKUP, 16'hffff, 32'hffff_ffff, PH_FREE, 1'b0);
        add_request(REQ_INSERT, 16'h8000, 32'h1234_5678, PH_FREE, 1'b0);
        add_request(REQ_INSERT, 16'h0000, 32'hffff_ffff, PH_FREE, 1'b0);
        add_request(REQ_INSERT, 16'hffff, 32'h0000_0000, PH_FREE, 1'b0);
        add_request(REQ_INSERT, 16'h4000, 32'ha5a5_a5a5, PH_FREE, 1'b0);
        add_request(REQ_LOOKUP, 16'h0000, 32'h0000_0000, PH_FREE, 1'b0);
        add_request(REQ_LOOKUP, 16'hffff, 32'h0000_0000, PH_FREE, 1'b0);
        add_request(REQ_LOOKUP, 16'h8000, 32'h0000_0000, PH_FREE, 1'b0);
        add_request(REQ_LOOKUP, 16'h7fff, 32'h0000_0000, PH_FREE, 1'b0);
        add_request(REQ_INSERT, 16'h8000, 32'h0000_0000, PH_FREE, 1'b0);
        add_request(REQ_LOOKUP, 16'h8000, 32'hffff_ffff, PH_FREE, 1'b0);
        add_request(REQ_INSERT, 16'h0000, 32'h5a5a_5a5a, PH_FREE, 1'b0);
        add_request(REQ_LOOKUP, 16'h0000, 32'h0000_0000, PH_FREE, 1'b0);
        add_request(REQ_INSERT, 16'h0001, 32'h0000_0001, PH_FREE, 1'b0);
        add_request(REQ_LOOKUP, 16'h4000, 32'hffff_ffff, PH_FREE, 1'b0);
        add_request(REQ_LOOKUP, 16'h0001, 32'h0000_0000, PH_FREE, 1'b0);
        add_request(REQ_LOOKUP, 16'h0002, 32'h0000_0000, PH_FREE, 1'b0);

        // random: mostly lookups, with inserts more frequent once the table fills, then full refusals and hits
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            ph = (n * 4) / RANDOM_ITEMS;
            if ($urandom_range(99) < ((gen_keys.size() < CAPACITY) ? 30 : 40)) begin
                req = REQ_INSERT;
                key = pick_key(20);
            end else begin
                req = REQ_LOOKUP;
                key = pick_key(60);
            end
            // first transfer of each phase waits for the block to drain
            add_request(req, key, 32'($urandom), ph, (n * 4) % RANDOM_ITEMS < 4);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid || expected_replies.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/skvt_pkg.sv
rtl/skvt_ram.sv
rtl/skvt_seq.sv
rtl/sorted_key_value_table_unit.sv
bench/sorted_key_value_table_unit_tb.sv
